FILE: rtl/core/mse_pkg.sv
// Package for the merge sort engine: sizes, data type and sequencer states.
// No dependencies; used by the stream interfaces and by merge_sort_engine.
package mse_pkg;

	localparam int CAPACITY = 64;                       // elements held per set, 1..64
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);         // buffer address
	localparam int CNT_W    = $clog2(CAPACITY + 1);     // counts 0..CAPACITY
	localparam int WID_W    = CNT_W + 1;                // run width, may reach 2**CNT_W
	localparam int SUM_W    = CNT_W + 2;                // lo + 2*width without wrap

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WID_W-1:0]  wid_t;
	typedef logic [SUM_W-1:0]  sum_t;

	typedef enum logic [2:0] {
		ST_LOAD,    // collect elements
		ST_SETUP,   // set up the next run pair, or finish the sort
		ST_MERGE,   // one element per cycle into the other buffer
		ST_EMIT,    // stream sorted elements out
		ST_DRAIN    // wait for the final transaction to be taken
	} state_t;

endpackage

FILE: rtl/core/mse_in_if.sv
// Input channel of the merge sort engine: valid/ready plus one element.
// Depends on mse_pkg.
interface mse_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [mse_pkg::DATA_W-1:0] value;
	logic                           last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: rtl/core/mse_out_if.sv
// Output channel of the merge sort engine: valid/ready plus one sorted element.
// Depends on mse_pkg.
interface mse_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [mse_pkg::DATA_W-1:0] sorted_value;
	logic                           end_of_run;
	logic                           truncated;

	modport source (output valid, output sorted_value, output end_of_run, output truncated,
		input ready);
	modport sink   (input valid, input sorted_value, input end_of_run, input truncated,
		output ready);
endinterface

FILE: rtl/core/merge_sort_engine.sv
// Merge sort engine: buffers a set, bottom-up stable merge sort, streams result.
// Load takes one element per cycle while in the load state; a sort of n elements runs
//   ceil(log2 n) passes, merging one element per cycle, with a setup step per run pair and a final setup;
// output gives one result per cycle while the sink is ready.
// The single compare/merge unit and one write port per buffer set the merge rate.
// arst_n clears the sequencer, counters and output valid; buffers are not cleared.
module merge_sort_engine (
	input  logic         clk,
	input  logic         arst_n,
	mse_in_if.sink       din,
	mse_out_if.source    dout
);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	mse_pkg::state_t state_q, state_d;

	mse_pkg::cnt_t count_q, count_d;     // elements buffered in this set
	logic          ovf_q, ovf_d;         // an element of this set was dropped

	// merge sequencer registers
	mse_pkg::wid_t w_q, w_d;             // current run width
	mse_pkg::cnt_t lo_q, lo_d;           // start of current run pair
	mse_pkg::cnt_t mid_q, mid_d;         // end of left run (clipped)
	mse_pkg::cnt_t hi_q, hi_d;           // end of right run (clipped)
	mse_pkg::cnt_t i_q, i_d;             // left run read pointer
	mse_pkg::cnt_t j_q, j_d;             // right run read pointer
	mse_pkg::cnt_t k_q, k_d;             // write pointer in destination
	logic          src_q, src_d;         // 0: read element_store, write scratch

	mse_pkg::cnt_t o_idx_q, o_idx_d;     // index whose data sits on read port A

	// output register
	logic          out_valid_q, out_valid_d;
	mse_pkg::data_t out_value_q;
	logic          out_end_q;
	logic          out_trunc_q;

	// two buffers used ping-pong between passes
	mse_pkg::data_t element_store_q [mse_pkg::CAPACITY];
	mse_pkg::data_t merge_scratch_q [mse_pkg::CAPACITY];
	mse_pkg::data_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------
	logic           in_fire;
	logic           has_room;
	logic           w_done;
	logic           take_a;
	logic           run_end;
	logic           pass_end;
	logic           out_load;
	logic           emit_last;
	mse_pkg::sum_t  mid_calc, hi_calc, lo_next;
	mse_pkg::cnt_t  mid_clip, hi_clip;
	mse_pkg::data_t rd_a, rd_b, merge_data;
	mse_pkg::addr_t ra_a, ra_b;

	logic           we0, we1;
	mse_pkg::addr_t wa0;
	mse_pkg::data_t wd0;

	assign in_fire  = din.valid && din.ready;
	assign has_room = count_q < mse_pkg::CNT_W'(mse_pkg::CAPACITY);

	// sort finished once a single run spans the set
	assign w_done   = w_q >= mse_pkg::WID_W'(count_q);

	assign mid_calc = mse_pkg::SUM_W'(lo_q) + mse_pkg::SUM_W'(w_q);
	assign hi_calc  = mid_calc + mse_pkg::SUM_W'(w_q);
	assign mid_clip = (mid_calc > mse_pkg::SUM_W'(count_q)) ? count_q
		: mid_calc[mse_pkg::CNT_W-1:0];
	assign hi_clip  = (hi_calc > mse_pkg::SUM_W'(count_q)) ? count_q
		: hi_calc[mse_pkg::CNT_W-1:0];

	assign rd_a = src_q ? rd1a_q : rd0a_q;
	assign rd_b = src_q ? rd1b_q : rd0b_q;

	// stable merge: left run wins on equal keys
	assign take_a = (i_q < mid_q) &&
		((j_q >= hi_q) || ($signed(rd_a) <= $signed(rd_b)));
	assign merge_data = take_a ? rd_a : rd_b;

	assign run_end  = (mse_pkg::WID_W'(k_q) + mse_pkg::WID_W'(1)) == mse_pkg::WID_W'(hi_q);
	assign lo_next  = mse_pkg::SUM_W'(lo_q) + (mse_pkg::SUM_W'(w_q) << 1);
	assign pass_end = lo_next >= mse_pkg::SUM_W'(count_q);

	assign out_load  = (state_q == mse_pkg::ST_EMIT) && (!out_valid_q || dout.ready);
	assign emit_last = (mse_pkg::WID_W'(o_idx_q) + mse_pkg::WID_W'(1))
		== mse_pkg::WID_W'(count_q);

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mse_pkg::ST_LOAD: begin
				if (in_fire && din.last) state_d = mse_pkg::ST_SETUP;
			end
			mse_pkg::ST_SETUP: begin
				state_d = w_done ? mse_pkg::ST_EMIT : mse_pkg::ST_MERGE;
			end
			mse_pkg::ST_MERGE: begin
				if (run_end) state_d = mse_pkg::ST_SETUP;
			end
			mse_pkg::ST_EMIT: begin
				if (out_load && emit_last) state_d = mse_pkg::ST_DRAIN;
			end
			mse_pkg::ST_DRAIN: begin
				if (dout.ready) state_d = mse_pkg::ST_LOAD;
			end
			default: state_d = mse_pkg::ST_LOAD;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer datapath and outputs
	// ------------------------------------------------------------------
	always_comb begin
		count_d     = count_q;
		ovf_d       = ovf_q;
		w_d         = w_q;
		lo_d        = lo_q;
		mid_d       = mid_q;
		hi_d        = hi_q;
		i_d         = i_q;
		j_d         = j_q;
		k_d         = k_q;
		src_d       = src_q;
		o_idx_d     = o_idx_q;
		out_valid_d = out_valid_q && !dout.ready;
		ra_a        = i_q[mse_pkg::ADDR_W-1:0];
		ra_b        = j_q[mse_pkg::ADDR_W-1:0];
		we0         = 1'b0;
		we1         = 1'b0;
		wa0         = k_q[mse_pkg::ADDR_W-1:0];
		wd0         = merge_data;

		unique case (state_q)
			mse_pkg::ST_LOAD: begin
				if (in_fire) begin
					if (has_room) begin
						we0     = 1'b1;
						wa0     = count_q[mse_pkg::ADDR_W-1:0];
						wd0     = din.value;
						count_d = count_q + mse_pkg::CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (din.last) begin
						w_d   = mse_pkg::WID_W'(1);
						lo_d  = '0;
						src_d = 1'b0;
					end
				end
			end
			mse_pkg::ST_SETUP: begin
				if (w_done) begin
					o_idx_d = '0;
					ra_a    = '0;
				end else begin
					mid_d = mid_clip;
					hi_d  = hi_clip;
					i_d   = lo_q;
					j_d   = mid_clip;
					k_d   = lo_q;
					ra_a  = lo_q[mse_pkg::ADDR_W-1:0];
					ra_b  = mid_clip[mse_pkg::ADDR_W-1:0];
				end
			end
			mse_pkg::ST_MERGE: begin
				we0 = src_q;
				we1 = !src_q;
				k_d = k_q + mse_pkg::CNT_W'(1);
				if (take_a) i_d = i_q + mse_pkg::CNT_W'(1);
				else        j_d = j_q + mse_pkg::CNT_W'(1);
				ra_a = i_d[mse_pkg::ADDR_W-1:0];
				ra_b = j_d[mse_pkg::ADDR_W-1:0];
				if (run_end) begin
					if (pass_end) begin
						lo_d  = '0;
						w_d   = w_q << 1;
						src_d = !src_q;
					end else begin
						lo_d = lo_next[mse_pkg::CNT_W-1:0];
					end
				end
			end
			mse_pkg::ST_EMIT: begin
				if (out_load) begin
					out_valid_d = 1'b1;
					o_idx_d     = o_idx_q + mse_pkg::CNT_W'(1);
				end
				ra_a = o_idx_d[mse_pkg::ADDR_W-1:0];
			end
			mse_pkg::ST_DRAIN: begin
				if (dout.ready) begin
					count_d = '0;
					ovf_d   = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign din.ready         = (state_q == mse_pkg::ST_LOAD);
	assign dout.valid        = out_valid_q;
	assign dout.sorted_value = out_value_q;
	assign dout.end_of_run   = out_end_q;
	assign dout.truncated    = out_trunc_q;

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mse_pkg::ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			w_q         <= '0;
			lo_q        <= '0;
			mid_q       <= '0;
			hi_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			src_q       <= 1'b0;
			o_idx_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			ovf_q       <= ovf_d;
			w_q         <= w_d;
			lo_q        <= lo_d;
			mid_q       <= mid_d;
			hi_q        <= hi_d;
			i_q         <= i_d;
			j_q         <= j_d;
			k_q         <= k_d;
			src_q       <= src_d;
			o_idx_q     <= o_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= rd_a;
			out_end_q   <= emit_last;
			out_trunc_q <= ovf_q;
		end
	end

	// ------------------------------------------------------------------
	// Buffers: one write port each, two registered read ports
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (we0) element_store_q[wa0] <= wd0;
		rd0a_q <= element_store_q[ra_a];
		rd0b_q <= element_store_q[ra_b];
	end

	always_ff @(posedge clk) begin
		if (we1) merge_scratch_q[k_q[mse_pkg::ADDR_W-1:0]] <= merge_data;
		rd1a_q <= merge_scratch_q[ra_a];
		rd1b_q <= merge_scratch_q[ra_b];
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mse_pkg::CNT_W'(mse_pkg::CAPACITY))
		else $error("element count above capacity");

	a_merge_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mse_pkg::ST_MERGE |->
			(i_q <= mid_q) && (j_q <= hi_q) && (k_q < hi_q))
		else $error("merge pointer out of run bounds");

	a_merge_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mse_pkg::ST_MERGE |->
			(mse_pkg::SUM_W'(k_q) + mse_pkg::SUM_W'(mid_q))
			== (mse_pkg::SUM_W'(i_q) + mse_pkg::SUM_W'(j_q)))
		else $error("merge write pointer out of step with read pointers");

	a_end_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.ready && dout.end_of_run |=>
			(state_q == mse_pkg::ST_LOAD) && (count_q == '0) && !ovf_q)
		else $error("set not cleared after final transaction");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		din.ready |-> !dout.valid)
		else $error("input taken while a result is pending");

endmodule

FILE: dv/merge_sort_engine_tb.sv
`timescale 1ns / 1ps
// Testbench for merge_sort_engine: streams sets of signed elements and checks the sorted output.
// Depends on mse_pkg, mse_in_if, mse_out_if and the engine itself.
module merge_sort_engine_tb;

	// One element waiting to be offered; wait_drain holds it back until every
	// sorted result expected so far has come out.
	typedef struct {
		mse_pkg::data_t value;
		logic           last;
		bit             wait_drain;
	} element_t;

	typedef struct packed {
		mse_pkg::data_t sorted_value;
		logic           end_of_run;
		logic           truncated;
	} result_t;

	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 100;   // quiet time after the last result

	logic clk = 1'b0;
	logic arst_n;

	mse_in_if  din_if ();
	mse_out_if dout_if ();

	merge_sort_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #4 clk = ~clk;

	element_t       element_q[$];     // elements still to be offered
	result_t        sorted_q[$];      // sorted results still to come out
	mse_pkg::data_t set_values[$];    // elements of the set being loaded, as the engine keeps them
	logic           set_dropped;      // an element of this set did not fit
	int             total_items;
	int             accepted_items;
	int             results_seen;
	int             errors;
	int             hold_left;
	bit             hold_done;

	// Predictor: buffer the element (drop it when full); on the last one sort
	// ascending, stable on equal keys, and queue one result per buffered element.
	function automatic void absorb_element(mse_pkg::data_t v, logic is_last);
		mse_pkg::data_t ordered[$];
		mse_pkg::data_t x;
		int             j;
		result_t        r;
		if (set_values.size() < mse_pkg::CAPACITY)
			set_values.push_back(v);
		else
			set_dropped = 1'b1;
		if (!is_last)
			return;
		// insertion keeps earlier equal keys first, same as the left run winning
		foreach (set_values[i]) begin
			x = set_values[i];
			j = ordered.size();
			while (j > 0 && $signed(ordered[j-1]) > $signed(x))
				j--;
			ordered.insert(j, x);
		end
		foreach (ordered[i]) begin
			r.sorted_value = ordered[i];
			r.end_of_run   = (i == ordered.size() - 1);
			r.truncated    = set_dropped;
			sorted_q.push_back(r);
		end
		set_values.delete();
		set_dropped = 1'b0;
	endfunction

	task automatic add_item(mse_pkg::data_t v, logic is_last, bit wait_drain = 1'b0);
		element_t e;
		e.value      = v;
		e.last       = is_last;
		e.wait_drain = wait_drain;
		element_q.push_back(e);
		total_items++;
	endtask

	// Mix of extremes, a narrow band full of ties, and full-range values.
	function automatic mse_pkg::data_t pick_value();
		case ($urandom_range(9))
			0:       return 32'h8000_0000 + $urandom_range(3);
			1:       return 32'h7fff_ffff - $urandom_range(3);
			2, 3:    return mse_pkg::data_t'($urandom_range(8)) - 32'd4;
			default: return $urandom();
		endcase
	endfunction

	task automatic add_set(int size, bit wait_drain);
		for (int i = 0; i < size; i++)
			add_item(pick_value(), i == size - 1, wait_drain && i == 0);
	endtask

	// Sender: one transaction per handshake; idles at random except in a
	// steady window, and obeys the drain marker on the head element.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.value <= '0;
			din_if.last  <= 1'b0;
		end else begin : drive_input
			element_t e;
			bit       steady;
			if (din_if.valid && din_if.ready) begin
				accepted_items <= accepted_items + 1;
				absorb_element(din_if.value, din_if.last);
			end
			steady = accepted_items >= 30 && accepted_items < 60;
			if (!din_if.valid || din_if.ready) begin
				if (element_q.size() != 0 && (steady || $urandom_range(99) >= 36)
						&& !(element_q[0].wait_drain && sorted_q.size() != 0)) begin
					e = element_q.pop_front();
					din_if.valid <= 1'b1;
					din_if.value <= e.value;
					din_if.last  <= e.last;
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls, a steady window, and one long hold-off
	// early on while the sender still has elements, so the engine backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			dout_if.ready <= 1'b0;
		end else if (!hold_done && results_seen >= 10) begin
			hold_left     <= HOLD_CYCLES;
			hold_done     <= 1'b1;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= (results_seen >= 30 && results_seen < 60) ||
				$urandom_range(99) >= 36;
		end
	end

	// Monitor: each output transaction against the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin : check_result
			result_t want;
			results_seen <= results_seen + 1;
			if (sorted_q.size() == 0) begin
				$error("unexpected result: sorted_value %0d", $signed(dout_if.sorted_value));
				errors++;
			end else begin
				want = sorted_q.pop_front();
				if (dout_if.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
						$signed(want.sorted_value), $signed(dout_if.sorted_value));
					errors++;
				end
				if (dout_if.end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b",
						want.end_of_run, dout_if.end_of_run);
					errors++;
				end
				if (dout_if.truncated !== want.truncated) begin
					$error("truncated: expected %0b, got %0b",
						want.truncated, dout_if.truncated);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int  small_left;
		int  size;
		int  pick;
		bit  over_done;
		bit  pause_done;
		arst_n         = 1'b0;
		din_if.valid   = 1'b0;
		din_if.value   = '0;
		din_if.last    = 1'b0;
		dout_if.ready  = 1'b0;
		set_dropped    = 1'b0;
		total_items    = 0;
		accepted_items = 0;
		results_seen   = 0;
		errors         = 0;

		// Directed: single-element set
		add_item(32'd0, 1'b1);
		// extremes of the value range, out of order
		add_item(32'h7fff_ffff, 1'b0);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'hffff_ffff, 1'b0);
		add_item(32'd0, 1'b0);
		add_item(32'd1, 1'b1);
		// ties, positive and negative
		add_item(32'd5, 1'b0);
		add_item(32'd5, 1'b0);
		add_item(-32'sd5, 1'b0);
		add_item(32'd5, 1'b0);
		add_item(-32'sd5, 1'b1);
		// reverse order, then already sorted
		add_item(32'd40, 1'b0);
		add_item(32'd30, 1'b0);
		add_item(32'hffff_ffec, 1'b0);
		add_item(32'h8000_0001, 1'b1);
		add_item(32'h8000_0000, 1'b0);
		add_item(32'd7, 1'b0);
		add_item(32'h7fff_fffe, 1'b1);
		// two-element set
		add_item(32'h7fff_ffff, 1'b0);
		add_item(32'h8000_0000, 1'b1);

		// Random sets: a few small ones and one that overflows (the buffer
		// fills exactly, then the rest, its last element too, is dropped), and
		// one set held back until everything before it has drained.
		small_left = 16;
		over_done  = 1'b0;
		pause_done = 1'b0;
		while (small_left > 0 || !over_done) begin
			pick = $urandom_range(9);
			if (!over_done && (pick <= 1 || small_left <= 0)) begin
				size      = mse_pkg::CAPACITY + $urandom_range(1, 6);
				over_done = 1'b1;
			end else begin
				size       = $urandom_range(1, 12);
				small_left = small_left - size;
			end
			add_set(size, !pause_done && small_left < 8);
			if (small_left < 8)
				pause_done = 1'b1;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (accepted_items == total_items);
		wait (sorted_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/mse_pkg.sv
rtl/core/mse_in_if.sv
rtl/core/mse_out_if.sv
rtl/core/merge_sort_engine.sv
dv/merge_sort_engine_tb.sv
